>>> sv/sba_pkg.sv
// shared constants for the slab bitmap allocator
// no dependencies; used by sba_if.sv and slab_bitmap_allocator.sv
package sba_pkg;

    localparam int POOL_PAGES       = 64;
    localparam int PAGE_BYTES       = 4096;
    localparam int BITMAP_WORD_BITS = 64;
    localparam int CUSTOM_CLASSES   = 4;
    localparam int DEFAULT_CLASSES  = 10;
    localparam int SLOTS_MAX        = PAGE_BYTES / 8;
    localparam int WORDS_PER_PAGE   = SLOTS_MAX / BITMAP_WORD_BITS;

    localparam int ADDR_W   = 18;
    localparam int SIZE_W   = 16;
    localparam int CSIZE_W  = 13;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [3:0] CLASS_UNASSIGNED = 4'd15;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_CUSTOM_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUSTOM_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUSTOM_C = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CUSTOM_D = 2'd3;

endpackage

>>> sv/sba_if.sv
// request and response channel interfaces of the slab bitmap allocator
// depends on sba_pkg
interface sba_req_if
    import sba_pkg::*;
(
);
    logic                valid;
    logic                ready;
    logic                opcode;
    logic [SIZE_W-1:0]   req_size;
    logic [ADDR_W-1:0]   free_addr;

    modport source (output valid, output opcode, output req_size, output free_addr,
                    input ready);
    modport sink   (input valid, input opcode, input req_size, input free_addr,
                    output ready);
endinterface

interface sba_rsp_if
    import sba_pkg::*;
(
);
    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   obj_addr;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output obj_addr, output status, input ready);
    modport sink   (input valid, input obj_addr, input status, output ready);
endinterface

>>> sv/slab_bitmap_allocator.sv
// slab bitmap allocator: one word at a time, page table and slot bitmap in sync rams
// alloc: class pick, 13-step divide, then a page table read per page visited and a bitmap
// read per word checked (8 bitmap words written on page claim); free: page read, divide, bitmap read
// throughput: one word in flight; the next request is taken once the result is staged
// reset: async active low clears control, cfg registers and the page fill count;
// rams need no clearing pass, a claimed page gets its 8 bitmap words written on claim
module slab_bitmap_allocator
    import sba_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    sba_req_if.sink              req,
    sba_rsp_if.source            rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CSIZE_W-1:0]   cfg_wdata
);

    typedef enum logic [4:0] {
        S_IDLE, S_A_CLASS, S_DIV, S_A_TOTAL, S_A_PAGE_RD, S_A_PAGE_CHK,
        S_A_WORD_RD, S_A_WORD_CHK, S_A_MUL, S_A_ADDR, S_CLAIM, S_CLAIM_W,
        S_F_START, S_F_PAGE, S_F_CHK, S_F_TAIL, S_F_WORD, S_RESULT
    } state_t;

    localparam logic [CSIZE_W-1:0] PAGE_SIZE_C = CSIZE_W'(PAGE_BYTES);
    localparam logic [9:0]         SLOTS_MAX_C = 10'(SLOTS_MAX);

    state_t              state_reg;
    logic                op_reg;
    logic [SIZE_W-1:0]   req_size_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [3:0]          cls_reg;
    logic [CSIZE_W-1:0]  size_reg;
    logic [9:0]          total_reg;
    logic [6:0]          page_reg;
    logic [2:0]          word_reg;
    logic [8:0]          slot_reg;
    logic [9:0]          pfree_reg;
    logic [3:0]          powner_reg;
    logic [6:0]          next_unused_reg;
    logic [CSIZE_W-1:0]  rem_reg;
    logic [CSIZE_W-1:0]  quo_reg;
    logic [CSIZE_W-1:0]  dvd_reg;
    logic [3:0]          div_cnt_reg;
    logic [22:0]         prod_reg;
    logic [ADDR_W-1:0]   res_addr_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                rsp_valid_reg;
    logic [ADDR_W-1:0]   rsp_addr_reg;
    logic [STATUS_W-1:0] rsp_status_reg;
    logic                rsp_load;
    logic [CSIZE_W-1:0]  custom_size_reg [CUSTOM_CLASSES];

    // page table ram: {owner class, free slot count}
    logic [13:0] page_mem [POOL_PAGES];
    logic [13:0] pg_rdata_reg;
    logic        pg_we;
    logic [5:0]  pg_waddr;
    logic [13:0] pg_wdata;
    logic [5:0]  pg_raddr;

    // slot bitmap ram, 8 words per page
    logic [BITMAP_WORD_BITS-1:0] bm_mem [POOL_PAGES * WORDS_PER_PAGE];
    logic [BITMAP_WORD_BITS-1:0] bm_rdata_reg;
    logic                        bm_we;
    logic [BITMAP_WORD_BITS-1:0] bm_wdata;
    logic [8:0]                  bm_addr;

    // object size of a class code, zero when the code has no usable size
    function automatic logic [CSIZE_W-1:0] class_size(input logic [3:0] code,
                                                      input logic [CSIZE_W-1:0] ca,
                                                      input logic [CSIZE_W-1:0] cb,
                                                      input logic [CSIZE_W-1:0] cc,
                                                      input logic [CSIZE_W-1:0] cd);
        logic [CSIZE_W-1:0] s;
        s = '0;
        case (code)
            4'd0:    s = ca;
            4'd1:    s = cb;
            4'd2:    s = cc;
            4'd3:    s = cd;
            4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13:
                     s = CSIZE_W'(13'd8 << (code - 4'd4));
            default: s = '0;
        endcase
        if (s > PAGE_SIZE_C)
            s = '0;
        return s;
    endfunction

    // class pick for an allocate: exact custom match first, else power-of-two round up
    logic [3:0]         sel_cls;
    logic [CSIZE_W-1:0] sel_size;
    logic               sel_too_large;

    always_comb
    begin
        sel_cls       = CLASS_UNASSIGNED;
        sel_size      = '0;
        sel_too_large = (req_size_reg > SIZE_W'(PAGE_BYTES));
        for (int k = DEFAULT_CLASSES - 1; k >= 0; k--)
        begin
            if ((17'd8 << k) >= {1'b0, req_size_reg})
            begin
                sel_cls  = 4'(CUSTOM_CLASSES + k);
                sel_size = CSIZE_W'(17'd8 << k);
            end
        end
        for (int k = CUSTOM_CLASSES - 1; k >= 0; k--)
        begin
            if (custom_size_reg[k] != '0 && custom_size_reg[k] <= PAGE_SIZE_C &&
                {3'b000, custom_size_reg[k]} == req_size_reg)
            begin
                sel_cls       = 4'(k);
                sel_size      = custom_size_reg[k];
                sel_too_large = 1'b0;
            end
        end
    end

    logic [CSIZE_W-1:0] owner_size;
    assign owner_size = class_size(pg_rdata_reg[13:10], custom_size_reg[0],
                                   custom_size_reg[1], custom_size_reg[2],
                                   custom_size_reg[3]);

    // first clear slot in the bitmap word, limited to slots below the page total
    logic        slot_found;
    logic [5:0]  slot_first;

    always_comb
    begin
        slot_found = 1'b0;
        slot_first = '0;
        for (int b = BITMAP_WORD_BITS - 1; b >= 0; b--)
        begin
            if (!bm_rdata_reg[b] && ({1'b0, word_reg, 6'(b)} < total_reg))
            begin
                slot_found = 1'b1;
                slot_first = 6'(b);
            end
        end
    end

    // restoring divider step
    logic [CSIZE_W-1:0] div_trial;
    logic               div_ge;
    assign div_trial = {rem_reg[CSIZE_W-2:0], dvd_reg[CSIZE_W-1]};
    assign div_ge    = (div_trial >= size_reg);

    logic [9:0] pfree_inc;
    assign pfree_inc = (pfree_reg < 10'd1023) ? pfree_reg + 10'd1 : pfree_reg;

    // ram port control
    always_comb
    begin
        pg_raddr = page_reg[5:0];
        pg_we    = 1'b0;
        pg_waddr = page_reg[5:0];
        pg_wdata = {cls_reg, pfree_reg - 10'd1};
        bm_addr  = {page_reg[5:0], word_reg};
        bm_we    = 1'b0;
        bm_wdata = bm_rdata_reg | (BITMAP_WORD_BITS'(1) << slot_first);
        case (state_reg)
            S_F_START:
                pg_raddr = addr_reg[17:12];
            S_A_WORD_CHK:
            begin
                pg_we = slot_found;
                bm_we = slot_found;
            end
            S_CLAIM:
            begin
                pg_we    = (next_unused_reg != 7'(POOL_PAGES));
                pg_waddr = next_unused_reg[5:0];
                pg_wdata = {cls_reg, total_reg - 10'd1};
            end
            S_CLAIM_W:
            begin
                bm_we    = 1'b1;
                bm_wdata = (word_reg == 3'd0) ? BITMAP_WORD_BITS'(1) : '0;
            end
            S_F_WORD:
            begin
                pg_we    = bm_rdata_reg[slot_reg[5:0]];
                pg_wdata = {powner_reg, pfree_inc};
                bm_we    = bm_rdata_reg[slot_reg[5:0]];
                bm_wdata = bm_rdata_reg & ~(BITMAP_WORD_BITS'(1) << slot_reg[5:0]);
            end
            default:
            begin
                pg_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pg_we)
            page_mem[pg_waddr] <= pg_wdata;
        pg_rdata_reg <= page_mem[pg_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (bm_we)
            bm_mem[bm_addr] <= bm_wdata;
        bm_rdata_reg <= bm_mem[bm_addr];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CUSTOM_CLASSES; i++)
                custom_size_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CUSTOM_A: custom_size_reg[0] <= cfg_wdata;
                CFG_CUSTOM_B: custom_size_reg[1] <= cfg_wdata;
                CFG_CUSTOM_C: custom_size_reg[2] <= cfg_wdata;
                CFG_CUSTOM_D: custom_size_reg[3] <= cfg_wdata;
                default:      custom_size_reg[0] <= custom_size_reg[0];
            endcase
        end
    end

    assign req.ready    = (state_reg == S_IDLE);
    assign rsp.valid    = rsp_valid_reg;
    assign rsp.obj_addr = rsp_addr_reg;
    assign rsp.status   = rsp_status_reg;

    // result moves into the output register when it is empty or being drained
    assign rsp_load = (state_reg == S_RESULT) && (!rsp_valid_reg || rsp.ready);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            next_unused_reg <= '0;
            rsp_valid_reg   <= 1'b0;
            div_cnt_reg     <= '0;
        end
        else
        begin
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && rsp.ready)
                rsp_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg       <= req.opcode;
                        req_size_reg <= req.req_size;
                        addr_reg     <= req.free_addr;
                        state_reg    <= (req.opcode == OP_FREE) ? S_F_START : S_A_CLASS;
                    end
                end
                S_A_CLASS:
                begin
                    if (sel_too_large)
                    begin
                        res_addr_reg   <= '0;
                        res_status_reg <= ST_TOO_LARGE;
                        state_reg      <= S_RESULT;
                    end
                    else
                    begin
                        cls_reg     <= sel_cls;
                        size_reg    <= sel_size;
                        dvd_reg     <= PAGE_SIZE_C;
                        rem_reg     <= '0;
                        quo_reg     <= '0;
                        div_cnt_reg <= 4'(CSIZE_W);
                        state_reg   <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg     <= div_ge ? div_trial - size_reg : div_trial;
                    quo_reg     <= {quo_reg[CSIZE_W-2:0], div_ge};
                    dvd_reg     <= {dvd_reg[CSIZE_W-2:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg - 4'd1;
                    if (div_cnt_reg == 4'd1)
                        state_reg <= (op_reg == OP_FREE) ? S_F_CHK : S_A_TOTAL;
                end
                S_A_TOTAL:
                begin
                    total_reg <= (quo_reg > CSIZE_W'(SLOTS_MAX)) ? SLOTS_MAX_C : quo_reg[9:0];
                    page_reg  <= '0;
                    state_reg <= S_A_PAGE_RD;
                end
                S_A_PAGE_RD:
                begin
                    state_reg <= (page_reg >= next_unused_reg) ? S_CLAIM : S_A_PAGE_CHK;
                end
                S_A_PAGE_CHK:
                begin
                    if (pg_rdata_reg[13:10] == cls_reg && pg_rdata_reg[9:0] != '0)
                    begin
                        pfree_reg <= pg_rdata_reg[9:0];
                        word_reg  <= '0;
                        state_reg <= S_A_WORD_RD;
                    end
                    else
                    begin
                        page_reg  <= page_reg + 7'd1;
                        state_reg <= S_A_PAGE_RD;
                    end
                end
                S_A_WORD_RD:
                    state_reg <= S_A_WORD_CHK;
                S_A_WORD_CHK:
                begin
                    if (slot_found)
                    begin
                        slot_reg  <= {word_reg, slot_first};
                        state_reg <= S_A_MUL;
                    end
                    else if (word_reg != 3'd7 && {word_reg + 3'd1, 6'd0} < total_reg)
                    begin
                        word_reg  <= word_reg + 3'd1;
                        state_reg <= S_A_WORD_RD;
                    end
                    else
                    begin
                        page_reg  <= page_reg + 7'd1;
                        state_reg <= S_A_PAGE_RD;
                    end
                end
                S_A_MUL:
                begin
                    prod_reg  <= 23'({14'd0, slot_reg} * {10'd0, size_reg});
                    state_reg <= S_A_ADDR;
                end
                S_A_ADDR:
                begin
                    res_addr_reg   <= {page_reg[5:0], 12'd0} + prod_reg[ADDR_W-1:0];
                    res_status_reg <= ST_OK;
                    state_reg      <= S_RESULT;
                end
                S_CLAIM:
                begin
                    if (next_unused_reg == 7'(POOL_PAGES))
                    begin
                        res_addr_reg   <= '0;
                        res_status_reg <= ST_EXHAUSTED;
                        state_reg      <= S_RESULT;
                    end
                    else
                    begin
                        page_reg  <= next_unused_reg;
                        word_reg  <= '0;
                        state_reg <= S_CLAIM_W;
                    end
                end
                S_CLAIM_W:
                begin
                    word_reg <= word_reg + 3'd1;
                    if (word_reg == 3'(WORDS_PER_PAGE - 1))
                    begin
                        next_unused_reg <= next_unused_reg + 7'd1;
                        res_addr_reg    <= {page_reg[5:0], 12'd0};
                        res_status_reg  <= ST_OK;
                        state_reg       <= S_RESULT;
                    end
                end
                S_F_START:
                begin
                    if ({1'b0, addr_reg[17:12]} >= next_unused_reg)
                    begin
                        res_addr_reg   <= '0;
                        res_status_reg <= ST_UNKNOWN;
                        state_reg      <= S_RESULT;
                    end
                    else
                    begin
                        page_reg  <= {1'b0, addr_reg[17:12]};
                        state_reg <= S_F_PAGE;
                    end
                end
                S_F_PAGE:
                begin
                    if (owner_size == '0)
                    begin
                        res_addr_reg   <= '0;
                        res_status_reg <= ST_UNKNOWN;
                        state_reg      <= S_RESULT;
                    end
                    else
                    begin
                        size_reg    <= owner_size;
                        powner_reg  <= pg_rdata_reg[13:10];
                        pfree_reg   <= pg_rdata_reg[9:0];
                        dvd_reg     <= {1'b0, addr_reg[11:0]};
                        rem_reg     <= '0;
                        quo_reg     <= '0;
                        div_cnt_reg <= 4'(CSIZE_W);
                        state_reg   <= S_DIV;
                    end
                end
                S_F_CHK:
                begin
                    if (quo_reg >= CSIZE_W'(SLOTS_MAX))
                    begin
                        res_addr_reg   <= '0;
                        res_status_reg <= ST_UNKNOWN;
                        state_reg      <= S_RESULT;
                    end
                    else
                    begin
                        slot_reg  <= quo_reg[8:0];
                        word_reg  <= quo_reg[8:6];
                        prod_reg  <= 23'(({1'b0, quo_reg[8:0]} + 10'd1) * size_reg);
                        state_reg <= S_F_TAIL;
                    end
                end
                S_F_TAIL:
                begin
                    // object would run past the page end: address lies in the tail
                    if (prod_reg > 23'(PAGE_BYTES))
                    begin
                        res_addr_reg   <= '0;
                        res_status_reg <= ST_UNKNOWN;
                        state_reg      <= S_RESULT;
                    end
                    else
                        state_reg <= S_F_WORD;
                end
                S_F_WORD:
                begin
                    res_addr_reg   <= '0;
                    res_status_reg <= bm_rdata_reg[slot_reg[5:0]] ? ST_OK : ST_ALREADY_FREE;
                    state_reg      <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (rsp_load)
                    begin
                        rsp_addr_reg   <= res_addr_reg;
                        rsp_status_reg <= res_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // page fill count never passes the pool size
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_unused_reg <= 7'(POOL_PAGES))
        else $error("page fill count past pool size");

    // a new response word only comes out of the result state
    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_RESULT))
        else $error("response raised outside result state");

    // a successful result always points into a claimed page
    a_ok_page: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_status_reg == ST_OK) |->
            ({1'b0, rsp_addr_reg[17:12]} < next_unused_reg))
        else $error("ok result outside claimed pages");

    // divider count runs only inside the divide state
    a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (div_cnt_reg != 4'd0) |-> (state_reg == S_DIV))
        else $error("divider active outside divide state");

endmodule
